@@ hw/rtl/fsc_pkg.sv @@
package fsc_pkg;

	localparam int NUM_MACH = 7;

	localparam int M_INT = 0;
	localparam int M_STR = 1;
	localparam int M_PTR = 2;
	localparam int M_CHR = 3;
	localparam int M_DBL = 4;
	localparam int M_LNG = 5;
	localparam int M_LLG = 6;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_PCT   = 2'd1;
	localparam logic [1:0] ST_PREC  = 2'd2;
	localparam logic [1:0] ST_LMOD  = 2'd3;
	localparam logic [1:0] ST_POUND = 2'd2;

	localparam logic [2:0] CLS_NONE = 3'd0;
	localparam logic [2:0] CLS_PTR  = 3'd3;

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_PCT     = 8'h25;
	localparam logic [7:0] CH_POUND   = 8'h23;
	localparam logic [7:0] CH_ELL     = 8'h6c;
	localparam logic [7:0] CH_BIG_ELL = 8'h4c;
	localparam logic [7:0] CH_X       = 8'h78;
	localparam logic [7:0] CH_BIG_X   = 8'h58;
	localparam logic [7:0] CH_S       = 8'h73;
	localparam logic [7:0] CH_BIG_S   = 8'h53;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_C       = 8'h63;
	localparam logic [7:0] CH_P       = 8'h70;
	localparam logic [7:0] CH_BIG_P   = 8'h50;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef struct packed {
		logic [1:0] st;
		logic       dec;
		logic       ver;
	} fsc_mach_t;

	typedef struct packed {
		fsc_mach_t [NUM_MACH-1:0] mach;
		logic [7:0]               earlier;
		logic [7:0]               lns_str;
		logic [7:0]               lns_chr;
		logic                     skip_ll;
		logic                     alt_hex;
	} fsc_state_t;

	typedef struct packed {
		logic [2:0] arg_class;
		logic       alt_hex_pointer;
	} fsc_result_t;

	function automatic logic fsc_is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c inside {[8'd9:8'd13]});
	endfunction

	function automatic fsc_mach_t fsc_decide(fsc_mach_t x, logic v);
		fsc_mach_t r;
		r = x;
		r.dec = 1'b1;
		r.ver = v;
		return r;
	endfunction

	function automatic fsc_mach_t fsc_pct(fsc_mach_t x);
		fsc_mach_t r;
		r = x;
		case (x.st)
			ST_IDLE: r.st = ST_PCT;
			ST_PCT:  r.st = ST_IDLE;
			default: r = fsc_decide(x, 1'b0);
		endcase
		return r;
	endfunction

	function automatic fsc_mach_t fsc_nod(fsc_mach_t x, logic [7:0] c);
		fsc_mach_t r;
		r = x;
		if ((c == CH_DOT || (c inside {["0":"9"]})) && x.st == ST_PCT)
			r.st = ST_PREC;
		return r;
	endfunction

	function automatic fsc_state_t fsc_process(fsc_state_t s, logic [7:0] c, logic [7:0] n);
		fsc_state_t r;
		fsc_mach_t  m;
		logic       pp;
		logic       any;
		logic [7:0] e;
		r = s;
		e = s.earlier;

		m = s.mach[M_INT];
		pp = (m.st == ST_PCT) || (m.st == ST_PREC);
		if (!m.dec) begin
			if (c == CH_PCT) m = fsc_pct(m);
			else if (c == CH_ELL || c == CH_BIG_ELL) begin
				if (pp) m = fsc_decide(m, 1'b0);
			end else if (c inside {"i", "d", "o", "u"}) begin
				if (pp) m = fsc_decide(m, 1'b1);
			end else if (c == CH_X || c == CH_BIG_X) m = fsc_decide(m, e != CH_POUND);
			else if (c inside {"e", "E", "f", "F", "g", "G", "a", "A", "c", "s", "P", "n",
					"m"}) begin
				if (pp) m = fsc_decide(m, 1'b0);
			end else m = fsc_nod(m, c);
			r.mach[M_INT] = m;
		end

		m = s.mach[M_STR];
		if (!m.dec) begin
			if (c == CH_PCT) m = fsc_pct(m);
			else if (c == CH_ELL) begin
				if (m.st == ST_PCT || m.st == ST_PREC) m.st = ST_LMOD;
			end else if (c == CH_S || c == CH_BIG_S) begin
				if (m.st == ST_PCT && s.lns_str == CH_PCT) m = fsc_decide(m, 1'b1);
				else if (m.st == ST_PREC || m.st == ST_LMOD) m = fsc_decide(m, 1'b1);
				else if (n == CH_NUL) m = fsc_decide(m, 1'b0);
			end else if (c inside {"d", "i", "o", "u", "x", "X", "e", "E", "f", "F", "g",
					"G", "a", "A", "c", "P", "n", "m"}) begin
				if (m.st != ST_IDLE) m = fsc_decide(m, 1'b0);
			end else m = fsc_nod(m, c);
			if (!fsc_is_space(c)) r.lns_str = c;
			r.mach[M_STR] = m;
		end

		m = s.mach[M_PTR];
		if (!m.dec) begin
			if (c == CH_PCT) m = fsc_pct(m);
			else if (c == CH_P || c == CH_BIG_P) begin
				if (m.st == ST_PCT) begin
					r.alt_hex = 1'b0;
					m = fsc_decide(m, 1'b1);
				end
			end else if (c == CH_POUND) begin
				if (m.st == ST_PCT) m.st = ST_POUND;
			end else if (c == CH_X || c == CH_BIG_X) begin
				if (m.st == ST_POUND) begin
					r.alt_hex = 1'b1;
					m = fsc_decide(m, 1'b1);
				end else if (m.st == ST_PCT) m = fsc_decide(m, 1'b0);
			end else if (c inside {"d", "i", "o", "u", "e", "E", "f", "F", "g", "G", "a",
					"A", "s", "c", "n", "m"}) begin
				if (m.st == ST_PCT || m.st == ST_POUND) m = fsc_decide(m, 1'b0);
			end
			r.mach[M_PTR] = m;
		end

		m = s.mach[M_CHR];
		if (!m.dec) begin
			if (c == CH_PCT) m = fsc_pct(m);
			else if (c == CH_DOT) begin
				if (m.st != ST_PREC) m = fsc_nod(m, c);
			end else if (c == CH_ELL) begin
				if (m.st == ST_PCT || m.st == ST_PREC) m.st = ST_LMOD;
			end else if (c == CH_C) begin
				if (m.st == ST_PCT && s.lns_chr == CH_PCT) m = fsc_decide(m, 1'b1);
			end else if (c inside {"d", "i", "o", "u", "x", "X", "e", "E", "f", "F", "g",
					"G", "a", "A", "s", "P", "n", "m"}) begin
				if (m.st == ST_PCT || m.st == ST_PREC) m = fsc_decide(m, 1'b0);
			end else m = fsc_nod(m, c);
			if (!fsc_is_space(c) && !(c == CH_DOT && s.mach[M_CHR].st == ST_PREC))
				r.lns_chr = c;
			r.mach[M_CHR] = m;
		end

		m = s.mach[M_DBL];
		if (!m.dec) begin
			if (c == CH_PCT) m = fsc_pct(m);
			else if (c == CH_ELL) begin
				if (m.st == ST_PCT || m.st == ST_PREC) m.st = ST_LMOD;
			end else if (c inside {"e", "E", "f", "F", "g", "G"}) begin
				if (m.st != ST_IDLE) m = fsc_decide(m, 1'b1);
			end else m = fsc_nod(m, c);
			r.mach[M_DBL] = m;
		end

		m = s.mach[M_LNG];
		pp = (m.st == ST_PCT) || (m.st == ST_PREC);
		any = (m.st != ST_IDLE);
		if (!m.dec) begin
			if (c == CH_PCT) m = fsc_pct(m);
			else if (c == CH_ELL) begin
				if (n == CH_ELL) m = fsc_decide(m, 1'b0);
				else if (pp) m.st = ST_LMOD;
			end else if (c == CH_BIG_ELL) begin
				if (pp) m = fsc_decide(m, 1'b0);
			end else if (c inside {"i", "d", "o", "u"}) begin
				if (any) m = fsc_decide(m, 1'b1);
			end else if (c == CH_X || c == CH_BIG_X) m = fsc_decide(m, e != CH_POUND);
			else if (c inside {"e", "E", "f", "F", "g", "G", "a", "A", "c", "s", "P", "n",
					"m"}) begin
				if (any) m = fsc_decide(m, 1'b0);
			end else m = fsc_nod(m, c);
			r.mach[M_LNG] = m;
		end

		m = s.mach[M_LLG];
		pp = (m.st == ST_PCT) || (m.st == ST_PREC);
		if (!m.dec) begin
			if (s.skip_ll) r.skip_ll = 1'b0;
			else begin
				if (c == CH_PCT) m = fsc_pct(m);
				else if (c == CH_BIG_ELL) begin
					if (pp) m.st = ST_LMOD;
				end else if (c == CH_ELL) begin
					if (pp && n == CH_ELL) begin
						r.skip_ll = 1'b1;
						m.st = ST_LMOD;
					end
				end else if (c inside {"i", "d", "o", "u", "x", "X"}) begin
					if (m.st == ST_LMOD) m = fsc_decide(m, 1'b1);
				end else if (c inside {"e", "E", "f", "F", "g", "G", "a", "A", "c", "s", "P",
						"n", "m"}) begin
					if (pp || m.st == ST_LMOD) m = fsc_decide(m, 1'b0);
				end else m = fsc_nod(m, c);
				r.mach[M_LLG] = m;
			end
		end

		r.earlier = c;
		return r;
	endfunction

endpackage

@@ hw/rtl/format_spec_type_classifier_top.sv @@
// Classifies a printf-style conversion one byte per cycle: bytes starting at the
// percent sign enter on the input channel, the final one flagged by is_last, and
// one result per string comes out with the argument class and the alternate hex
// flag. A byte is taken every cycle while no finished result waits on the output;
// a final byte that finds the result register full and stalled is held in the input
// register and stalls the input. The final byte passes through the input register and
// then the result register, which presents the result until it transfers. Each byte
// is judged with the next byte as lookahead, so every byte but the last is held until
// its successor arrives; the final byte and the held one are resolved in the same
// cycle.
module format_spec_type_classifier_top import fsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       is_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] arg_class,
	output logic       alt_hex_pointer
);

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;
	logic        advance;
	logic        in_xfer;
	logic        out_valid_q;
	fsc_result_t res;
	fsc_result_t res_q;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	fsc_bank u_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_code (char_s1),
		.is_last   (last_s1),
		.result    (res)
	);

	// hold the result until its transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) res_q <= res;
	end

	assign out_valid       = out_valid_q;
	assign arg_class       = res_q.arg_class;
	assign alt_hex_pointer = res_q.alt_hex_pointer;

endmodule

@@ hw/rtl/fsc_bank.sv @@
module fsc_bank import fsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  char_code,
	input  logic        is_last,
	output fsc_result_t result
);

	fsc_state_t state_q;
	fsc_state_t mid;
	fsc_state_t fin;
	logic [7:0] held_q;
	logic       held_valid_q;

	always_comb begin
		mid = held_valid_q ? fsc_process(state_q, held_q, char_code) : state_q;
		fin = fsc_process(mid, char_code, CH_NUL);
		result.arg_class = CLS_NONE;
		for (int i = NUM_MACH - 1; i >= 0; i--) begin
			if (fin.mach[i].dec && fin.mach[i].ver) result.arg_class = 3'(i + 1);
		end
		result.alt_hex_pointer = (result.arg_class == CLS_PTR) && fin.alt_hex;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= '0;
			held_valid_q <= 1'b0;
		end else if (step) begin
			if (is_last) begin
				state_q      <= '0;
				held_valid_q <= 1'b0;
			end else begin
				state_q      <= mid;
				held_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && !is_last) held_q <= char_code;
	end

endmodule
